/* rtl/bezier_curve_point_evaluator_defines.svh */
// ----------------------------------------------------------------------------
// Bezier curve point evaluator: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_POINT_EVALUATOR_DEFINES_SVH
`define BEZIER_CURVE_POINT_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCPE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bcpe_pkg.sv */
// ----------------------------------------------------------------------------
// bcpe_pkg
// Types, constants and the binomial table shared by the Bezier evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

    localparam int MAX_POINTS = 8;
    localparam int IDX_W      = 3;
    localparam int DEG_W      = 3;
    localparam int COORD_W    = 32;
    localparam int T_W        = 17;
    localparam int Q_W        = 31;              // unsigned Q1.30
    localparam int Q_FRAC     = 30;
    localparam int MUL_W      = 33;              // signed multiplier operand
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 64;
    localparam int BINOM_W    = 6;

    localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd3;
    localparam logic [T_W-1:0]   T_ONE        = 17'h10000;
    localparam logic [Q_W-1:0]   ONE_Q30      = 31'h4000_0000;

    // Pascal triangle, rows n = 0..7
    localparam logic [BINOM_W-1:0] BINOM_TABLE [8][8] = '{
        '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
        '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
        '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
    };

    function automatic logic [BINOM_W-1:0] binom_coef(input logic [DEG_W-1:0] n,
                                                      input logic [IDX_W-1:0] r);
        return BINOM_TABLE[n][r];
    endfunction

    // Operation issued to the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_TPOW,
        MUL_UPOW,
        MUL_PROD,
        MUL_BINOM,
        MUL_X,
        MUL_Y
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TPOW,
        ST_UPOW,
        ST_PROD,
        ST_BINOM,
        ST_MULX,
        ST_MULY,
        ST_DRAIN,
        ST_ROUND
    } ctrl_state_t;

    typedef struct packed {
        logic             start;
        logic             load;
        logic             round;
        mul_op_t          op;
        logic [IDX_W-1:0] t_addr;
        logic [IDX_W-1:0] u_addr;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] pt_idx;
        logic [DEG_W-1:0] degree;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

/* rtl/bezier_curve_point_evaluator.sv */
// Sequence: an evaluation steps from acceptance through the powers, the basis and coordinate
// products of each point, a drain and rounding to a valid result; a load gives no result.
// Throughput: one item at a time, paced by the single shared 33x33 multiplier that runs
// two power steps per degree and four products per control point.
// Reset: degree is 3, all control points are zero, no result is pending.
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator
// Planar Bezier curve evaluator in Bernstein form: loads control points and
// evaluates the curve at t, giving a rounded, clipped Q16.16 point.
// ----------------------------------------------------------------------------
`include "bezier_curve_point_evaluator_defines.svh"

module bezier_curve_point_evaluator
    import bcpe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [DEG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      func,
    input  logic [IDX_W-1:0]          point_index,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic [T_W-1:0]            t_param,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] curve_x,
    output logic signed [COORD_W-1:0] curve_y,
    output logic                      saturated
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bcpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .status   (status),
        .cmd      (cmd)
    );

    bcpe_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .t_param     (t_param),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .saturated   (saturated)
    );

    // An evaluate transaction makes the block busy
    `BCPE_ASSERT_NEXT(a_eval_busy, clk, rst_n, in_valid && in_ready && func, !in_ready, "evaluate did not start")
    // A load transaction leaves the block ready again in the next cycle
    `BCPE_ASSERT_NEXT(a_load_quick, clk, rst_n, in_valid && in_ready && !func, in_ready, "load stalled the input")
    // A result appears only at the end of an evaluation
    `BCPE_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(!in_ready), "result without evaluation")

endmodule

/* rtl/bcpe_ctrl.sv */
// ----------------------------------------------------------------------------
// bcpe_ctrl
// Sequencer: holds the degree register and steps the shared multiplier
// through the power, basis and coordinate products of one evaluation.
// ----------------------------------------------------------------------------
module bcpe_ctrl
    import bcpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             func,
    input  logic             cfg_we,
    input  logic [DEG_W-1:0] cfg_data,
    input  dp_status_t       status,
    output dp_cmd_t          cmd
);

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [DEG_W-1:0] degree_reg;

    // State, counters and degree register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            k_reg      <= '0;
            i_reg      <= '0;
            degree_reg <= DEGREE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            if (cfg_we)
            begin
                degree_reg <= cfg_data;
            end
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.op     = MUL_NONE;
        cmd.degree = degree_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func)
                    begin
                        cmd.start = 1'b1;
                        i_next    = '0;
                        k_next    = IDX_W'(1);
                        // degree zero needs no powers
                        state_next = (degree_reg == '0) ? ST_PROD : ST_TPOW;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_TPOW:
            begin
                cmd.op     = MUL_TPOW;
                cmd.t_addr = k_reg - IDX_W'(1);
                cmd.wr_idx = k_reg;
                state_next = ST_UPOW;
            end
            ST_UPOW:
            begin
                cmd.op     = MUL_UPOW;
                cmd.u_addr = k_reg - IDX_W'(1);
                cmd.wr_idx = k_reg;
                if (k_reg == degree_reg)
                begin
                    state_next = ST_PROD;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_TPOW;
                end
            end
            ST_PROD:
            begin
                cmd.op     = MUL_PROD;
                cmd.t_addr = i_reg;
                cmd.u_addr = degree_reg - i_reg;
                cmd.pt_idx = i_reg;
                state_next = ST_BINOM;
            end
            ST_BINOM:
            begin
                cmd.op     = MUL_BINOM;
                cmd.pt_idx = i_reg;
                state_next = ST_MULX;
            end
            ST_MULX:
            begin
                cmd.op     = MUL_X;
                cmd.pt_idx = i_reg;
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                cmd.op     = MUL_Y;
                cmd.pt_idx = i_reg;
                if (i_reg == degree_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_PROD;
                end
            end
            ST_DRAIN:
            begin
                // let the last y product reach its sum
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.round  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/bcpe_datapath.sv */
// ----------------------------------------------------------------------------
// bcpe_datapath
// Control point store, power tables, one shared 33x33 multiplier, the two
// coordinate sums, rounding with clipping and the output register.
// ----------------------------------------------------------------------------
module bcpe_datapath
    import bcpe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic [IDX_W-1:0]          point_index,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic [T_W-1:0]            t_param,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [COORD_W-1:0] curve_x,
    output logic signed [COORD_W-1:0] curve_y,
    output logic                      saturated
);

    localparam logic [ACC_W:0] ROUND_HALF = (ACC_W+1)'(1) << (Q_FRAC - 1);

    logic signed [COORD_W-1:0] cp_x_reg [MAX_POINTS];
    logic signed [COORD_W-1:0] cp_y_reg [MAX_POINTS];
    logic [Q_W-1:0]            tp_reg   [MAX_POINTS];
    logic [Q_W-1:0]            up_reg   [MAX_POINTS];
    logic [Q_W-1:0]            t30_reg;
    logic [Q_W-1:0]            u30_reg;
    logic [Q_W-1:0]            p_reg;
    logic [Q_W-1:0]            basis_reg;
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   acc_x_reg;
    logic signed [ACC_W-1:0]   acc_y_reg;
    mul_op_t                   pend_reg;
    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] curve_x_reg;
    logic signed [COORD_W-1:0] curve_y_reg;
    logic                      saturated_reg;

    logic [T_W-1:0]            t_clamp;
    logic [Q_W-1:0]            t30_next;
    logic [Q_W-1:0]            tp_rd;
    logic [Q_W-1:0]            up_rd;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_res;
    logic [Q_W-1:0]            mul_q30;
    logic [COORD_W:0]          rx;
    logic [COORD_W:0]          ry;

    // Round a Q.30-scaled sum to nearest (ties up), clip; returns {sat, value}
    function automatic logic [COORD_W:0] round_clip(input logic signed [ACC_W-1:0] s);
        logic [ACC_W:0]           v;
        logic [ACC_W-Q_FRAC:0]    q;
        logic [COORD_W-1:0]       r;
        logic                     sat;
        v   = {s[ACC_W-1], s} + ROUND_HALF;
        q   = v[ACC_W:Q_FRAC];
        sat = !((q[ACC_W-Q_FRAC:COORD_W-1] == '0) || (q[ACC_W-Q_FRAC:COORD_W-1] == '1));
        if (!sat)
        begin
            r = q[COORD_W-1:0];
        end
        else if (q[ACC_W-Q_FRAC])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return {sat, r};
    endfunction

    // Clamp t to 1.0 and scale to Q1.30
    assign t_clamp  = (t_param > T_ONE) ? T_ONE : t_param;
    assign t30_next = {t_clamp, {(Q_W-T_W){1'b0}}};

    assign tp_rd = tp_reg[cmd.t_addr];
    assign up_rd = up_reg[cmd.u_addr];

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_TPOW:
            begin
                mul_a = {2'b00, tp_rd};
                mul_b = {2'b00, t30_reg};
            end
            MUL_UPOW:
            begin
                mul_a = {2'b00, up_rd};
                mul_b = {2'b00, u30_reg};
            end
            MUL_PROD:
            begin
                mul_a = {2'b00, tp_rd};
                mul_b = {2'b00, up_rd};
            end
            MUL_BINOM:
            begin
                mul_a = {{(MUL_W-BINOM_W){1'b0}}, binom_coef(cmd.degree, cmd.pt_idx)};
                mul_b = {2'b00, p_reg};
            end
            MUL_X:
            begin
                mul_a = {2'b00, basis_reg};
                mul_b = {cp_x_reg[cmd.pt_idx][COORD_W-1], cp_x_reg[cmd.pt_idx]};
            end
            MUL_Y:
            begin
                mul_a = {2'b00, basis_reg};
                mul_b = {cp_y_reg[cmd.pt_idx][COORD_W-1], cp_y_reg[cmd.pt_idx]};
            end
        endcase
    end

    assign mul_res = mul_a * mul_b;
    assign mul_q30 = mul_res[Q_FRAC+Q_W-1:Q_FRAC];

    // Control point store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_POINTS; j++)
            begin
                cp_x_reg[j] <= '0;
                cp_y_reg[j] <= '0;
            end
        end
        else if (cmd.load)
        begin
            cp_x_reg[point_index] <= point_x;
            cp_y_reg[point_index] <= point_y;
        end
    end

    // Power tables, basis and product registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            t30_reg   <= t30_next;
            u30_reg   <= ONE_Q30 - t30_next;
            tp_reg[0] <= ONE_Q30;
            up_reg[0] <= ONE_Q30;
        end
        if (cmd.op == MUL_TPOW)
        begin
            tp_reg[cmd.wr_idx] <= mul_q30;
        end
        if (cmd.op == MUL_UPOW)
        begin
            up_reg[cmd.wr_idx] <= mul_q30;
        end
        if (cmd.op == MUL_PROD)
        begin
            p_reg <= mul_q30;
        end
        if (cmd.op == MUL_BINOM)
        begin
            basis_reg <= mul_res[Q_W-1:0];
        end
        if (cmd.op == MUL_X || cmd.op == MUL_Y)
        begin
            prod_reg <= mul_res[ACC_W-1:0];
        end
    end

    // Accumulate the registered x or y product that pend_reg marks; clear both sums on start
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (pend_reg == MUL_X)
        begin
            acc_x_reg <= acc_x_reg + prod_reg;
        end
        else if (pend_reg == MUL_Y)
        begin
            acc_y_reg <= acc_y_reg + prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= MUL_NONE;
        end
        else
        begin
            pend_reg <= cmd.op;
        end
    end

    // Round both sums into the output register
    assign rx = round_clip(acc_x_reg);
    assign ry = round_clip(acc_y_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            curve_x_reg   <= rx[COORD_W-1:0];
            curve_y_reg   <= ry[COORD_W-1:0];
            saturated_reg <= rx[COORD_W] | ry[COORD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.round)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg & ~out_ready;
    assign out_valid       = out_valid_reg;
    assign curve_x         = curve_x_reg;
    assign curve_y         = curve_y_reg;
    assign saturated       = saturated_reg;

endmodule
